@@ rtl/bitmap_run_block_allocator_top_assert.svh @@
// Assertion macros for the run block allocator top level.
`ifndef BITMAP_RUN_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_RUN_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BRBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define BRBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/brba_pkg.sv @@
// Package with sizes, codes and types shared by the run block allocator.
package brba_pkg;

  localparam int unsigned MAP_BLOCKS = 256;
  localparam int unsigned WORD_W     = 8;
  localparam int unsigned OFF_W      = $clog2(WORD_W);
  localparam int unsigned NUM_WORDS  = MAP_BLOCKS / WORD_W;
  localparam int unsigned ADDR_W     = $clog2(NUM_WORDS);
  localparam int unsigned BLK_W      = ADDR_W + OFF_W;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned END_W      = ((BLK_W > IDX_W) ? BLK_W : IDX_W) + 1;
  localparam int unsigned GRANT_MAX  = 255;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic             set;
    logic [CNT_W-1:0] run;
    logic [CNT_W-1:0] count;
    logic [END_W-1:0] lo;
    logic [END_W-1:0] hi;
  } word_op_t;

  typedef struct packed {
    logic              found;
    logic [OFF_W-1:0]  off;
    logic [CNT_W-1:0]  run;
    logic [WORD_W-1:0] wdata;
  } word_res_t;

endpackage

@@ rtl/bitmap_run_block_allocator_top.sv @@
// Top level of the first-fit run block allocator over an occupancy bitmap.
//
//  Channel | Direction | Handshake              | Word
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid_i/in_ready_o   | req_type_i, start_block_i, block_count_i
//  out     | output    | out_valid_o/out_ready_i | success_o, granted_block_o
//
// The map sits in a RAM of 32 eight-bit words; the shared word unit handles one word a cycle.
// An allocate scans the words in order until a fitting run is found or the last word is seen,
// then marks the words the run spans. A free marks the words its range spans.
// After reset the map reads as block 0 used and all others free, with no clearing pass.
// The input is taken only in idle; a result waiting in the output register does not block it.
module bitmap_run_block_allocator_top
  import brba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             req_type_i,
  input  logic [IDX_W-1:0] start_block_i,
  input  logic [CNT_W-1:0] block_count_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             success_o,
  output logic [IDX_W-1:0] granted_block_o
);

  state_e            state_q, state_d;
  logic [ADDR_W:0]   iss_q, iss_d;
  logic [ADDR_W-1:0] last_w_q, last_w_d;
  logic              ev_vld_q, ev_vld_d;
  logic [ADDR_W-1:0] ev_w_q, ev_w_d;
  logic              rowv_rd_q;
  logic [NUM_WORDS-1:0] rowv_q;
  logic [CNT_W-1:0]  run_q, run_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [END_W-1:0]  lo_q, lo_d;
  logic [END_W-1:0]  hi_q, hi_d;
  logic              set_q, set_d;
  logic              res_ok_q, res_ok_d;
  logic [IDX_W-1:0]  res_blk_q, res_blk_d;
  logic              out_valid_q, out_valid_d;
  logic              success_q;
  logic [IDX_W-1:0]  granted_q;
  logic              load_out;

  logic              ram_re;
  logic              ram_we;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] ev_word;
  word_op_t          op;
  word_res_t         res;

  logic [END_W-1:0]  in_lo;
  logic [END_W-1:0]  in_hi_raw;
  logic [END_W-1:0]  in_hi;
  logic [END_W-1:0]  in_hi_m1;
  logic [BLK_W-1:0]  pos;
  logic [END_W-1:0]  first;

  brba_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_WORDS)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ev_w_q),
    .wdata_i(res.wdata),
    .re_i   (ram_re),
    .raddr_i(iss_q[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign ev_word = rowv_rd_q ? ram_rdata
                 : ((ev_w_q == '0) ? WORD_W'(1) : '0);

  assign op.set   = set_q;
  assign op.run   = run_q;
  assign op.count = count_q;
  assign op.lo    = lo_q;
  assign op.hi    = hi_q;

  brba_word_unit u_word_unit (
    .data_i(ev_word),
    .word_i(ev_w_q),
    .op_i  (op),
    .res_o (res)
  );

  assign in_lo     = END_W'(start_block_i);
  assign in_hi_raw = in_lo + END_W'(block_count_i);
  assign in_hi     = (in_hi_raw > END_W'(MAP_BLOCKS)) ? END_W'(MAP_BLOCKS) : in_hi_raw;
  assign in_hi_m1  = in_hi - END_W'(1);
  assign pos       = {ev_w_q, res.off};
  assign first     = END_W'(pos) + END_W'(1) - END_W'(count_q);

  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    last_w_d  = last_w_q;
    ev_vld_d  = 1'b0;
    ev_w_d    = iss_q[ADDR_W-1:0];
    run_d     = run_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    set_d     = set_q;
    res_ok_d  = res_ok_q;
    res_blk_d = res_blk_q;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    load_out  = 1'b0;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          count_d   = block_count_i;
          res_blk_d = '0;
          if (req_type_i == REQ_ALLOC) begin
            if (block_count_i == '0) begin
              res_ok_d = 1'b0;
              state_d  = ST_RESP;
            end else begin
              iss_d    = '0;
              last_w_d = ADDR_W'(NUM_WORDS - 1);
              run_d    = '0;
              state_d  = ST_SCAN;
            end
          end else begin
            res_ok_d = 1'b1;
            if (in_lo >= in_hi) begin
              state_d = ST_RESP;
            end else begin
              lo_d     = in_lo;
              hi_d     = in_hi;
              set_d    = 1'b0;
              iss_d    = {1'b0, in_lo[OFF_W +: ADDR_W]};
              last_w_d = in_hi_m1[OFF_W +: ADDR_W];
              state_d  = ST_MARK;
            end
          end
        end
      end
      ST_SCAN, ST_MARK: begin
        if (iss_q <= {1'b0, last_w_q}) begin
          ram_re   = 1'b1;
          ev_vld_d = 1'b1;
          iss_d    = iss_q + (ADDR_W+1)'(1);
        end
        if (ev_vld_q) begin
          if (state_q == ST_SCAN) begin
            run_d = res.run;
            if (res.found) begin
              ev_vld_d = 1'b0;
              if (first > END_W'(GRANT_MAX)) begin
                res_ok_d  = 1'b0;
                state_d   = ST_RESP;
              end else begin
                res_ok_d  = 1'b1;
                res_blk_d = first[IDX_W-1:0];
                lo_d      = first;
                hi_d      = END_W'(pos) + END_W'(1);
                set_d     = 1'b1;
                iss_d     = {1'b0, first[OFF_W +: ADDR_W]};
                last_w_d  = ev_w_q;
                state_d   = ST_MARK;
              end
            end else if (ev_w_q == ADDR_W'(NUM_WORDS - 1)) begin
              res_ok_d = 1'b0;
              state_d  = ST_RESP;
            end
          end else begin
            ram_we = 1'b1;
            if (ev_w_q == last_w_q) begin
              ev_vld_d = 1'b0;
              state_d  = ST_RESP;
            end
          end
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ev_vld_q    <= 1'b0;
      rowv_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ev_vld_q    <= ev_vld_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        rowv_q[ev_w_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q     <= iss_d;
    last_w_q  <= last_w_d;
    ev_w_q    <= ev_w_d;
    run_q     <= run_d;
    count_q   <= count_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    set_q     <= set_d;
    res_ok_q  <= res_ok_d;
    res_blk_q <= res_blk_d;
    if (ram_re) begin
      rowv_rd_q <= rowv_q[iss_q[ADDR_W-1:0]];
    end
    if (load_out) begin
      success_q <= res_ok_q;
      granted_q <= res_blk_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign success_o       = success_q;
  assign granted_block_o = granted_q;

`include "bitmap_run_block_allocator_top_assert.svh"

  `BRBA_ASSERT_NXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != ST_IDLE, "Idle.")
  `BRBA_ASSERT_IMP(a_write_only_mark, ram_we, state_q == ST_MARK, "Write outside mark.")
  `BRBA_ASSERT_IMP(a_fail_grant_zero, out_valid_o && !success_o, granted_block_o == '0, "Grant.")
  `BRBA_ASSERT_IMP(a_mark_in_range, ev_vld_q && (state_q == ST_MARK), ev_w_q <= last_w_q, "Range.")

endmodule

@@ rtl/brba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module brba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/brba_word_unit.sv @@
// Shared word unit: free-run scan with carried length and range mark of one map word.
module brba_word_unit
  import brba_pkg::*;
(
  input  logic [WORD_W-1:0] data_i,
  input  logic [ADDR_W-1:0] word_i,
  input  word_op_t          op_i,
  output word_res_t         res_o
);

  always_comb begin
    logic [CNT_W-1:0] run;
    logic [END_W-1:0] bidx;
    res_o       = '0;
    run         = op_i.run;
    for (int j = 0; j < WORD_W; j++) begin
      if (data_i[j]) begin
        run = '0;
      end else begin
        run = run + CNT_W'(1);
      end
      if (!res_o.found && (run == op_i.count)) begin
        res_o.found = 1'b1;
        res_o.off   = OFF_W'(j);
      end
      bidx = END_W'({word_i, OFF_W'(j)});
      if ((bidx >= op_i.lo) && (bidx < op_i.hi)) begin
        res_o.wdata[j] = op_i.set;
      end else begin
        res_o.wdata[j] = data_i[j];
      end
    end
    res_o.run = run;
  end

endmodule
